// ===== rtl/pgrl_pkg.sv =====
// pgrl_pkg: shared widths, register indexes and reset values for the
// palette gamma rgb565 lookup unit and its port checker.
// no dependencies.
package pgrl_pkg;

   // field widths of the transaction channels
   localparam int unsigned INDEX_W   = 8;
   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned POS_X_W   = 9;
   localparam int unsigned POS_Y_W   = 8;
   localparam int unsigned COLOR_W   = 16;
   localparam int unsigned ADDR_W    = 18;

   // configuration register widths
   localparam int unsigned GAMMA_W   = 8;
   localparam int unsigned WIDTH_W   = 10;
   localparam int unsigned HEIGHT_W  = 9;
   localparam int unsigned PITCH_W   = 10;
   localparam int unsigned OFFSET_W  = 6;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 10;

   // row plus offset needs one bit more than the row
   localparam int unsigned ROW_W     = 9;

   // command codes
   localparam logic CMD_PALETTE_WRITE = 1'b0;
   localparam logic CMD_PIXEL         = 1'b1;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAMMA        = 3'd0,
      CSR_FRAME_WIDTH  = 3'd1,
      CSR_FRAME_HEIGHT = 3'd2,
      CSR_SCREEN_PITCH = 3'd3,
      CSR_ROW_OFFSET   = 3'd4
   } csr_index_type;

   // register reset values
   localparam logic [GAMMA_W-1:0]  GAMMA_RST  = 8'd255;
   localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 10'd320;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 9'd200;
   localparam logic [PITCH_W-1:0]  PITCH_RST  = 10'd320;
   localparam logic [OFFSET_W-1:0] OFFSET_RST = 6'd20;

endpackage

// ===== rtl/palette_gamma_rgb565_lookup_unit.sv =====
// Palette lookup unit: 8-bit indexed pixels to RGB565 with brightness scaling.
// The palette (PALETTE_ENTRIES x 24 bits) sits in one synchronous memory with
// a registered read. A palette-write transaction writes the memory and gives
// no result. A pixel inside frame_width x frame_height gives one result: the
// memory is read at the edge that takes it, then comes the gamma multiply, then
// divide-by-255 and pack into the output register.
// Out-of-frame pixels are dropped at the input.
// One transaction is taken every clock while the result side keeps up; the
// input stalls only when all three stages hold results and rsp_stall is high.
// Palette entries are undefined until written; the memory gets no clearing.
// depends on: pgrl_pkg
module palette_gamma_rgb565_lookup_unit
   import pgrl_pkg::*;
#(
   parameter int unsigned PALETTE_ENTRIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [INDEX_W-1:0]    req_entry_index,
   input  logic [CHAN_W-1:0]     req_red,
   input  logic [CHAN_W-1:0]     req_green,
   input  logic [CHAN_W-1:0]     req_blue,
   input  logic [POS_X_W-1:0]    req_pos_x,
   input  logic [POS_Y_W-1:0]    req_pos_y,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COLOR_W-1:0]    rsp_pixel_color,
   output logic [ADDR_W-1:0]     rsp_dest_address,
   // configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_wdata
);

   localparam int unsigned MEM_AW  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int unsigned ENTRY_W = 3 * CHAN_W;
   localparam int unsigned PROD_W  = 2 * CHAN_W;

   // floor(p / 255) for a 16-bit product, exact over the whole range
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
      logic [PROD_W:0] t;
      t = {1'b0, p} + {9'd0, p[PROD_W-1:CHAN_W]} + 17'd1;
      return t[PROD_W-1:CHAN_W];
   endfunction

   // configuration registers
   logic [GAMMA_W-1:0]  gamma_ff,  gamma_in;
   logic [WIDTH_W-1:0]  width_ff,  width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [PITCH_W-1:0]  pitch_ff,  pitch_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;

   // pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_ready, s2_ready, s1_ready;
   logic req_accept, pix_keep, pix_load, pal_write, idx_ok;

   // stage 1 payload (memory read data lands here too)
   logic [ENTRY_W-1:0]  palette_mem [PALETTE_ENTRIES];
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic                s1_idx_ok_ff, s1_idx_ok_in;
   logic [POS_X_W-1:0]  s1_x_ff, s1_x_in;
   logic [ROW_W-1:0]    s1_row_ff, s1_row_in;
   logic [ENTRY_W-1:0]  s1_entry;

   // stage 2 payload
   logic [PROD_W-1:0]   s2_red_ff, s2_red_in;
   logic [PROD_W-1:0]   s2_green_ff, s2_green_in;
   logic [PROD_W-1:0]   s2_blue_ff, s2_blue_in;
   logic [ADDR_W-1:0]   s2_base_ff, s2_base_in;
   logic [POS_X_W-1:0]  s2_x_ff, s2_x_in;
   logic [ROW_W+PITCH_W-1:0] row_prod;

   // output register
   logic [COLOR_W-1:0]  out_color_ff, out_color_in;
   logic [ADDR_W-1:0]   out_addr_ff, out_addr_in;
   logic [CHAN_W-1:0]   red_q, green_q, blue_q;

   // handshake
   assign out_ready  = !out_valid_ff || !rsp_stall;
   assign s2_ready   = !s2_valid_ff || out_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_stall  = !s1_ready;
   assign req_accept = req_valid && s1_ready;
   assign csr_ready  = 1'b1;

   // input decode: clip, index range
   assign idx_ok    = {1'b0, req_entry_index} < (INDEX_W+1)'(PALETTE_ENTRIES);
   assign pix_keep  = ({1'b0, req_pos_x} < width_ff) && ({1'b0, req_pos_y} < height_ff);
   assign pix_load  = req_accept && (req_cmd == CMD_PIXEL) && pix_keep;
   assign pal_write = req_accept && (req_cmd == CMD_PALETTE_WRITE) && idx_ok;

   // configuration writes
   always_comb begin
      gamma_in  = gamma_ff;
      width_in  = width_ff;
      height_in = height_ff;
      pitch_in  = pitch_ff;
      offset_in = offset_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GAMMA:        gamma_in  = csr_wdata[GAMMA_W-1:0];
            CSR_FRAME_WIDTH:  width_in  = csr_wdata[WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: height_in = csr_wdata[HEIGHT_W-1:0];
            CSR_SCREEN_PITCH: pitch_in  = csr_wdata[PITCH_W-1:0];
            CSR_ROW_OFFSET:   offset_in = csr_wdata[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff  <= GAMMA_RST;
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         pitch_ff  <= PITCH_RST;
         offset_ff <= OFFSET_RST;
      end else begin
         gamma_ff  <= gamma_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         pitch_ff  <= pitch_in;
         offset_ff <= offset_in;
      end
   end

   // palette memory: write on palette transaction, read on kept pixel
   always_ff @(posedge clock) begin
      if (pal_write) begin
         palette_mem[req_entry_index[MEM_AW-1:0]] <= {req_red, req_green, req_blue};
      end
      if (pix_load) begin
         rd_data_ff <= palette_mem[req_entry_index[MEM_AW-1:0]];
      end
   end

   // valid bits of the three stages
   always_comb begin
      s1_valid_in  = s1_ready ? pix_load : s1_valid_ff;
      s2_valid_in  = s2_ready ? s1_valid_ff : s2_valid_ff;
      out_valid_in = out_ready ? s2_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // stage 1: position and row sum
   always_comb begin
      s1_idx_ok_in = s1_idx_ok_ff;
      s1_x_in      = s1_x_ff;
      s1_row_in    = s1_row_ff;
      if (pix_load) begin
         s1_idx_ok_in = idx_ok;
         s1_x_in      = req_pos_x;
         s1_row_in    = {1'b0, req_pos_y} + ROW_W'(offset_ff);
      end
   end

   // stage 2: gamma products and row base
   assign s1_entry = s1_idx_ok_ff ? rd_data_ff : '0;
   assign row_prod = s1_row_ff * pitch_ff;

   always_comb begin
      s2_red_in   = s2_red_ff;
      s2_green_in = s2_green_ff;
      s2_blue_in  = s2_blue_ff;
      s2_base_in  = s2_base_ff;
      s2_x_in     = s2_x_ff;
      if (s2_ready && s1_valid_ff) begin
         s2_red_in   = s1_entry[3*CHAN_W-1:2*CHAN_W] * gamma_ff;
         s2_green_in = s1_entry[2*CHAN_W-1:CHAN_W] * gamma_ff;
         s2_blue_in  = s1_entry[CHAN_W-1:0] * gamma_ff;
         s2_base_in  = row_prod[ADDR_W-1:0];
         s2_x_in     = s1_x_ff;
      end
   end

   // output stage: divide by 255, pack 5-6-5, add column
   assign red_q   = div255(s2_red_ff);
   assign green_q = div255(s2_green_ff);
   assign blue_q  = div255(s2_blue_ff);

   always_comb begin
      out_color_in = out_color_ff;
      out_addr_in  = out_addr_ff;
      if (out_ready && s2_valid_ff) begin
         out_color_in = {red_q[CHAN_W-1:3], green_q[CHAN_W-1:2], blue_q[CHAN_W-1:3]};
         out_addr_in  = s2_base_ff + ADDR_W'(s2_x_ff);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_idx_ok_ff <= s1_idx_ok_in;
      s1_x_ff      <= s1_x_in;
      s1_row_ff    <= s1_row_in;
      s2_red_ff    <= s2_red_in;
      s2_green_ff  <= s2_green_in;
      s2_blue_ff   <= s2_blue_in;
      s2_base_ff   <= s2_base_in;
      s2_x_ff      <= s2_x_in;
      out_color_ff <= out_color_in;
      out_addr_ff  <= out_addr_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_color  = out_color_ff;
   assign rsp_dest_address = out_addr_ff;

endmodule

// ===== rtl/pgrl_checker.sv =====
// pgrl_checker: port-level assertions for the palette lookup unit,
// bound to palette_gamma_rgb565_lookup_unit below.
// depends on: pgrl_pkg, palette_gamma_rgb565_lookup_unit
module pgrl_checker
   import pgrl_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [COLOR_W-1:0] rsp_pixel_color,
   input logic [ADDR_W-1:0]  rsp_dest_address
);

   // a stalled response holds its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_pixel_color) && $stable(rsp_dest_address))
      else $error("response changed while stalled");

   // input backs up only when the output is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with free output");

   // no response out of reset before the pipeline can fill
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid ##1 !rsp_valid)
      else $error("response right after reset");

   // a response that appears without input needs an earlier transaction
   a_no_ghost: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !req_valid ##1 !rsp_valid && !req_valid ##1 !rsp_valid && !req_valid
         |=> !rsp_valid)
      else $error("response without a request");

endmodule

bind palette_gamma_rgb565_lookup_unit pgrl_checker u_pgrl_checker (.*);
